// ===== sv/gyro_bias_calibrator_defines.svh =====
// Assertion macros used by the checker file of the gyro bias calibrator.
`ifndef GYRO_BIAS_CALIBRATOR_DEFINES_SVH
`define GYRO_BIAS_CALIBRATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define GBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbc assertion failed");

// Consequent checked in the cycle after the antecedent.
`define GBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbc assertion failed");

`endif

// ===== sv/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// Types, widths and saturation helpers of the gyro bias calibrator.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int CNT_W     = 16;
  localparam int GAIN_W    = 24;
  localparam int CFG_W     = 24;
  localparam int OFFSET_W  = 35;
  localparam int SUM_W     = 51;
  localparam int READ_W    = 36;
  localparam int WIDE_W    = 52;
  localparam int DIV_CNT_W = $clog2(WIDE_W);

  typedef enum logic [1:0] {
    ACT_BLOCK = 2'd0,
    ACT_CONT  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic {
    REG_CALIB_COUNT = 1'b0,
    REG_CONV_GAIN   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_ACCUM,
    S_MUL,
    S_ADD,
    S_DIV_START,
    S_DIV_WAIT,
    S_READ
  } state_e;

  typedef struct packed {
    logic load;
    logic scale;
    logic accum;
    logic mul;
    logic add;
    logic div_start;
    logic offset_wr;
    logic read_wr;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    block_done;
    logic    div_done;
    logic    out_busy;
  } status_t;

  function automatic logic signed [OFFSET_W-1:0] sat_offset(
    input logic signed [WIDE_W-1:0] v
  );
    logic all1;
    logic all0;
    all1 = &v[WIDE_W-1:OFFSET_W-1];
    all0 = ~|v[WIDE_W-1:OFFSET_W-1];
    if (all1 || all0) begin
      return v[OFFSET_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(OFFSET_W-1){1'b0}}};
    end else begin
      return {1'b0, {(OFFSET_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(
    input logic signed [WIDE_W-1:0] v
  );
    logic all1;
    logic all0;
    all1 = &v[WIDE_W-1:SUM_W-1];
    all0 = ~|v[WIDE_W-1:SUM_W-1];
    if (all1 || all0) begin
      return v[SUM_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SUM_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [READ_W-1:0] sat_read(
    input logic signed [WIDE_W-1:0] v
  );
    logic all1;
    logic all0;
    all1 = &v[WIDE_W-1:READ_W-1];
    all0 = ~|v[WIDE_W-1:READ_W-1];
    if (all1 || all0) begin
      return v[READ_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(READ_W-1){1'b0}}};
    end else begin
      return {1'b0, {(READ_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== sv/gyro_bias_calibrator.sv =====
// ----------------------------------------------------------------------------
// gyro_bias_calibrator
// Zero-rate offset calibration and readout for one analog gyro axis.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes an action with an axis and a
// reference ADC sample. Output channel (out_valid_o/out_ready_i) carries
// rate_reading_o, produced only by a read beat.
// One beat is in flight at a time; in_ready_o is high only when idle.
// Steps of an accepted beat after its load, before the next accept:
//   read:                 scale, then write of the output register
//   block sample:         scale, accumulate; the closing beat also divides
//   continuous sample:    scale, multiply, add, divide
// Dividing paths use the serial divider, one quotient bit per cycle over a
// 52-bit dividend. The output register holds a result while the receiver
// stalls; the block keeps accepting beats, and a later read waits only until
// that register drains. Reset clears offset, sum and sample count and loads
// calib_count = 100, conversion_gain = 1.0 (Q8.16). Configuration (cfg_we_i,
// cfg_index_i, cfg_data_i) must be written only while idle; not enforced here.
// ----------------------------------------------------------------------------
module gyro_bias_calibrator #(
  parameter int ADC_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic        [gbc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [1:0]                  action_i,
  input  logic        [ADC_BITS-1:0]         axis_sample_i,
  input  logic        [ADC_BITS-1:0]         ref_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [gbc_pkg::READ_W-1:0]  rate_reading_o
);

  gbc_pkg::cmd_t    cmd;
  gbc_pkg::status_t status;

  gbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbc_datapath #(
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .axis_sample_i  (axis_sample_i),
    .ref_sample_i   (ref_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rate_reading_o (rate_reading_o)
  );

endmodule

// ===== sv/gbc_divider.sv =====
// ----------------------------------------------------------------------------
// gbc_divider
// Serial restoring divider, signed dividend by unsigned count, one quotient
// bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module gbc_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [gbc_pkg::WIDE_W-1:0]     dividend_i,
  input  logic        [gbc_pkg::CNT_W-1:0]      divisor_i,
  output logic                                  done_o,
  output logic signed [gbc_pkg::WIDE_W-1:0]     quotient_o
);

  localparam int WIDE_W    = gbc_pkg::WIDE_W;
  localparam int CNT_W     = gbc_pkg::CNT_W;
  localparam int DIV_CNT_W = gbc_pkg::DIV_CNT_W;

  logic                 busy_q;
  logic                 done_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [WIDE_W-1:0]    quo_q;
  logic [CNT_W-1:0]     rem_q;

  logic [WIDE_W-1:0]    mag;
  logic [CNT_W:0]       trial;
  logic                 ge;
  logic [CNT_W:0]       rem_sub;
  logic [CNT_W-1:0]     rem_d;
  logic                 last;

  assign mag     = dividend_i[WIDE_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign trial   = {rem_q, quo_q[WIDE_W-1]};
  assign ge      = trial >= {1'b0, divisor_i};
  assign rem_sub = trial - {1'b0, divisor_i};
  assign rem_d   = ge ? rem_sub[CNT_W-1:0] : trial[CNT_W-1:0];
  assign last    = cnt_q == DIV_CNT_W'(WIDE_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[WIDE_W-1];
      quo_q <= mag;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[WIDE_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? $signed(~quo_q + 1'b1) : $signed(quo_q);

endmodule

// ===== sv/gbc_datapath.sv =====
// ----------------------------------------------------------------------------
// gbc_datapath
// Configuration registers, scaling multiplier, block accumulator, offset,
// running-average multiplier, shared divider and the output register.
// ----------------------------------------------------------------------------
module gbc_datapath #(
  parameter int ADC_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gbc_pkg::cmd_t                         cmd_i,
  output gbc_pkg::status_t                      status_o,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_index_i,
  input  logic        [gbc_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic        [1:0]                     action_i,
  input  logic        [ADC_BITS-1:0]            axis_sample_i,
  input  logic        [ADC_BITS-1:0]            ref_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [gbc_pkg::READ_W-1:0]     rate_reading_o
);

  localparam int SCALED_W = ADC_BITS + 25;
  localparam int WIDE_W   = gbc_pkg::WIDE_W;
  localparam int CNT_W    = gbc_pkg::CNT_W;
  localparam int GAIN_W   = gbc_pkg::GAIN_W;
  localparam int OFFSET_W = gbc_pkg::OFFSET_W;
  localparam int SUM_W    = gbc_pkg::SUM_W;
  localparam int READ_W   = gbc_pkg::READ_W;

  logic [CNT_W-1:0]           count_q;
  logic [GAIN_W-1:0]          gain_q;
  gbc_pkg::action_e           action_q;
  logic signed [ADC_BITS:0]   diff_q;
  logic signed [SCALED_W-1:0] scaled_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]           samples_q;
  logic signed [OFFSET_W-1:0] offset_q;
  logic signed [WIDE_W-1:0]   prod_q;
  logic                       out_valid_q;
  logic signed [READ_W-1:0]   out_q;

  logic [ADC_BITS:0]          diff_d;
  logic signed [SCALED_W:0]   scale_prod;
  logic [CNT_W-1:0]           eff_n;
  logic [CNT_W-1:0]           n_minus1;
  logic [CNT_W:0]             samples_inc;
  logic                       block_done;
  logic signed [WIDE_W-1:0]   scaled_wide;
  logic signed [WIDE_W-1:0]   sum_wide;
  logic signed [WIDE_W-1:0]   offset_wide;
  logic signed [WIDE_W-1:0]   mul_prod;
  logic signed [WIDE_W-1:0]   dividend;
  logic signed [WIDE_W-1:0]   quotient;
  logic                       div_done;

  assign diff_d      = {1'b0, axis_sample_i} - {1'b0, ref_sample_i};
  assign scale_prod  = (SCALED_W+1)'(diff_q) * (SCALED_W+1)'($signed({1'b0, gain_q}));
  assign eff_n       = (count_q == '0) ? CNT_W'(1) : count_q;
  assign n_minus1    = eff_n - 1'b1;
  assign samples_inc = {1'b0, samples_q} + 1'b1;
  assign block_done  = samples_inc >= {1'b0, eff_n};
  assign scaled_wide = WIDE_W'(scaled_q);
  assign sum_wide    = WIDE_W'(sum_q);
  assign offset_wide = WIDE_W'(offset_q);
  assign mul_prod    = WIDE_W'(offset_q) * WIDE_W'($signed({1'b0, n_minus1}));
  assign dividend    = (action_q == gbc_pkg::ACT_BLOCK) ? sum_wide : prod_q;

  gbc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (eff_n),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CNT_W'(100);
      gain_q      <= GAIN_W'(65536);
      samples_q   <= '0;
      sum_q       <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (gbc_pkg::reg_idx_e'(cfg_index_i))
          gbc_pkg::REG_CALIB_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
          gbc_pkg::REG_CONV_GAIN:   gain_q  <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accum) begin
        // first beat of a block restarts the sum
        if (samples_q == '0) begin
          sum_q <= scaled_wide[SUM_W-1:0];
        end else begin
          sum_q <= gbc_pkg::sat_sum(sum_wide + scaled_wide);
        end
        samples_q <= block_done ? '0 : samples_inc[CNT_W-1:0];
      end
      if (cmd_i.offset_wr) begin
        offset_q <= gbc_pkg::sat_offset(quotient);
      end
      if (cmd_i.read_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= gbc_pkg::action_e'(action_i);
      diff_q   <= $signed(diff_d);
    end
    if (cmd_i.scale) begin
      scaled_q <= scale_prod[SCALED_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= mul_prod;
    end else if (cmd_i.add) begin
      prod_q <= prod_q + scaled_wide;
    end
    if (cmd_i.read_wr) begin
      out_q <= gbc_pkg::sat_read(scaled_wide - offset_wide);
    end
  end

  assign status_o.action     = action_q;
  assign status_o.block_done = block_done;
  assign status_o.div_done   = div_done;
  assign status_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign rate_reading_o = out_q;

endmodule

// ===== sv/gbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbc_ctrl
// Sequencer: steps each accepted beat through scaling, then accumulation
// (dividing on a block's last beat), running average and division, or readout.
// ----------------------------------------------------------------------------
module gbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gbc_pkg::status_t status_i,
  output gbc_pkg::cmd_t    cmd_o
);

  gbc_pkg::state_e state_q;
  gbc_pkg::state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gbc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = gbc_pkg::S_SCALE;
        end
      end
      gbc_pkg::S_SCALE: begin
        cmd_o.scale = 1'b1;
        case (status_i.action)
          gbc_pkg::ACT_BLOCK: state_d = gbc_pkg::S_ACCUM;
          gbc_pkg::ACT_CONT:  state_d = gbc_pkg::S_MUL;
          gbc_pkg::ACT_READ:  state_d = gbc_pkg::S_READ;
          default:            state_d = gbc_pkg::S_IDLE;
        endcase
      end
      gbc_pkg::S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.block_done ? gbc_pkg::S_DIV_START : gbc_pkg::S_IDLE;
      end
      gbc_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = gbc_pkg::S_ADD;
      end
      gbc_pkg::S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = gbc_pkg::S_DIV_START;
      end
      gbc_pkg::S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = gbc_pkg::S_DIV_WAIT;
      end
      gbc_pkg::S_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.offset_wr = 1'b1;
          state_d         = gbc_pkg::S_IDLE;
        end
      end
      gbc_pkg::S_READ: begin
        // hold until the output register is free or drains this cycle
        if (!status_i.out_busy) begin
          cmd_o.read_wr = 1'b1;
          state_d       = gbc_pkg::S_IDLE;
        end
      end
      default: state_d = gbc_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/gbc_checker.sv =====
// ----------------------------------------------------------------------------
// gbc_checker
// Port-level checks of the gyro bias calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "gyro_bias_calibrator_defines.svh"

module gbc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic        [1:0]                 action_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [gbc_pkg::READ_W-1:0] rate_reading_o
);

  `GBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  `GBC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(rate_reading_o))

  // one beat at a time: the input closes right after an accept
  `GBC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // a read accepted with an empty output register raises out_valid after its scale and read states
  `GBC_ASSERT_NOW(a_read_latency, clk_i, rst_ni, in_valid_i && in_ready_o && (action_i == gbc_pkg::ACT_READ) && !out_valid_o, ##3 out_valid_o)

endmodule

bind gyro_bias_calibrator gbc_checker u_gbc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .action_i       (action_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .rate_reading_o (rate_reading_o)
);
